>>> sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Shared types and byte constants for the MIDI message assembler.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam logic [7:0] StatusLow    = 8'h80;
  localparam logic [7:0] StatusHigh   = 8'hEF;
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [3:0] KindProgram  = 4'hC;
  localparam logic [3:0] KindPressure = 4'hD;
  localparam logic [1:0] LenShort     = 2'd2;
  localparam logic [1:0] LenLong      = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_SYSEX  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] first;
    logic [6:0] second;
    logic [1:0] length;
    logic       stale;
  } msg_t;

endpackage

>>> sv/mma_parser.sv
// ----------------------------------------------------------------------------
// MIDI message assembler parser
// Parser state, held message bytes and the next-state logic for one byte.
// ----------------------------------------------------------------------------
module mma_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output logic               emit_o,
  output mma_pkg::msg_t      msg_o
);

  mma_pkg::phase_e phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [6:0] first_q, first_d;
  logic [6:0] second_q, second_d;
  logic       is_chan;
  logic       is_data;
  logic       short_kind;

  assign is_chan    = (byte_i inside {[mma_pkg::StatusLow:mma_pkg::StatusHigh]});
  assign is_data    = ~byte_i[7];
  assign short_kind = (status_q[7:4] == mma_pkg::KindProgram) ||
                      (status_q[7:4] == mma_pkg::KindPressure);

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    first_d  = first_q;
    second_d = second_q;
    emit_o   = 1'b0;
    msg_o    = '{status: status_q, first: first_q, second: second_q,
                 length: mma_pkg::LenLong, stale: 1'b0};
    case (phase_q)
      mma_pkg::PH_IDLE: begin
        if (is_chan) begin
          status_d = byte_i;
          phase_d  = mma_pkg::PH_FIRST;
        end else if (byte_i == mma_pkg::SysexStart) begin
          phase_d = mma_pkg::PH_SYSEX;
        end
      end
      mma_pkg::PH_FIRST: begin
        if (is_data) begin
          first_d = byte_i[6:0];
          if (short_kind) begin
            phase_d      = mma_pkg::PH_IDLE;
            emit_o       = 1'b1;
            msg_o.first  = byte_i[6:0];
            msg_o.second = 7'd0;
            msg_o.length = mma_pkg::LenShort;
          end else begin
            phase_d = mma_pkg::PH_SECOND;
          end
        end else begin
          phase_d = mma_pkg::PH_IDLE;
        end
      end
      mma_pkg::PH_SECOND: begin
        phase_d = mma_pkg::PH_IDLE;
        emit_o  = 1'b1;
        if (is_data) begin
          second_d     = byte_i[6:0];
          msg_o.second = byte_i[6:0];
        end else begin
          msg_o.stale = 1'b1;
        end
      end
      mma_pkg::PH_SYSEX: begin
        if (byte_i == mma_pkg::SysexEnd) begin
          phase_d = mma_pkg::PH_IDLE;
        end else if (is_chan) begin
          status_d = byte_i;
          phase_d  = mma_pkg::PH_FIRST;
        end
      end
      default: begin
        phase_d = mma_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mma_pkg::PH_IDLE;
      status_q <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      status_q <= status_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

>>> sv/mma_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI message assembler output register
// Holds one completed message until the downstream side takes it.
// ----------------------------------------------------------------------------
module mma_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mma_pkg::msg_t msg_i,
  input  logic          stall_i,
  output logic          ready_o,
  output logic          valid_o,
  output mma_pkg::msg_t msg_o
);

  logic          valid_q, valid_d;
  mma_pkg::msg_t msg_q;

  assign ready_o = ~valid_q | ~stall_i;
  assign valid_d = load_i | (valid_q & stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
  end

  assign valid_o = valid_q;
  assign msg_o   = msg_q;

endmodule

>>> sv/midi_message_assembler_core.sv
// ----------------------------------------------------------------------------
// MIDI message assembler core
// Builds channel messages from a stream of received MIDI bytes.
// ----------------------------------------------------------------------------
// One received byte is taken per item and the block accepts a byte in every
// cycle while the output side keeps up. A byte is registered on entry in the
// input register and parsed from there, and any completed message is then
// registered in the output register. A byte that completes a message waits
// in the input register while the output register is full and stalled;
// bytes that complete nothing pass through regardless. Program change and
// channel pressure give two-byte messages; a status byte arriving in place of
// the second data byte completes the message with the previously held second
// byte and sets second_stale.
module midi_message_assembler_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] msg_status_o,
  output logic [6:0] msg_first_o,
  output logic [6:0] msg_second_o,
  output logic [1:0] msg_length_o,
  output logic       second_stale_o
);

  logic          in_valid_q;
  logic [7:0]    byte_q;
  logic          consume;
  logic          emit;
  logic          out_ready;
  mma_pkg::msg_t msg;
  mma_pkg::msg_t out_msg;

  assign consume    = in_valid_q & (~emit | out_ready);
  assign in_stall_o = in_valid_q & ~consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  mma_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (consume),
    .byte_i (byte_q),
    .emit_o (emit),
    .msg_o  (msg)
  );

  mma_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (consume & emit),
    .msg_i   (msg),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .msg_o   (out_msg)
  );

  assign msg_status_o   = out_msg.status;
  assign msg_first_o    = out_msg.first;
  assign msg_second_o   = out_msg.second;
  assign msg_length_o   = out_msg.length;
  assign second_stale_o = out_msg.stale;

endmodule

>>> verif/midi_message_assembler_core_tb.sv
// ----------------------------------------------------------------------------
// MIDI message assembler core testbench
// Drives received MIDI bytes into the assembler and checks every completed
// message against a cycle-free model of the parser. The model keeps its own
// phase, held status and data bytes. A short directed sequence covers each
// message kind but pitch bend, which it only aborts, and every corner of
// the parser: ignored bytes, aborted messages, stale second bytes and system
// exclusive. It is followed by randomised message streams. The sender works
// in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module midi_message_assembler_core_tb;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;

  class midi_msg_scoreboard;
    mma_pkg::phase_e parse_state;
    logic [7:0]      status_r;
    logic [6:0]      first_r;
    logic [6:0]      second_r;
    mma_pkg::msg_t   pending[$];
    int unsigned     failures;
    int unsigned     checked;
    int unsigned     stale_seen;
    int unsigned     short_seen;

    function new();
      parse_state = mma_pkg::PH_IDLE;
      status_r    = '0;
      first_r     = '0;
      second_r    = '0;
      failures    = 0;
      checked     = 0;
      stale_seen  = 0;
      short_seen  = 0;
    endfunction

    // Advances the parser model by one accepted byte. Returns 0 when the byte
    // is simply ignored by the parser.
    function bit note_byte(logic [7:0] b);
      mma_pkg::msg_t m;
      bit            used;
      used = 1'b1;
      case (parse_state)
        mma_pkg::PH_IDLE: begin
          if (b >= mma_pkg::StatusLow && b <= mma_pkg::StatusHigh) begin
            status_r    = b;
            parse_state = mma_pkg::PH_FIRST;
          end else if (b == mma_pkg::SysexStart) begin
            parse_state = mma_pkg::PH_SYSEX;
          end else begin
            used = 1'b0;
          end
        end
        mma_pkg::PH_FIRST: begin
          if (!b[7]) begin
            first_r = b[6:0];
            if (status_r[7:4] == mma_pkg::KindProgram ||
                status_r[7:4] == mma_pkg::KindPressure) begin
              m = '{status: status_r, first: first_r, second: 7'd0,
                    length: mma_pkg::LenShort, stale: 1'b0};
              pending.push_back(m);
              parse_state = mma_pkg::PH_IDLE;
            end else begin
              parse_state = mma_pkg::PH_SECOND;
            end
          end else begin
            parse_state = mma_pkg::PH_IDLE;
          end
        end
        mma_pkg::PH_SECOND: begin
          parse_state = mma_pkg::PH_IDLE;
          if (!b[7]) second_r = b[6:0];
          m = '{status: status_r, first: first_r, second: second_r,
                length: mma_pkg::LenLong, stale: b[7]};
          pending.push_back(m);
        end
        default: begin
          if (b == mma_pkg::SysexEnd) begin
            parse_state = mma_pkg::PH_IDLE;
          end else if (b >= mma_pkg::StatusLow && b <= mma_pkg::StatusHigh) begin
            status_r    = b;
            parse_state = mma_pkg::PH_FIRST;
          end else begin
            used = 1'b0;
          end
        end
      endcase
      return used;
    endfunction

    function void check_msg(logic [7:0] st, logic [6:0] f, logic [6:0] s,
                            logic [1:0] len, logic stale);
      mma_pkg::msg_t m;
      if (pending.size() == 0) begin
        $error("Message status %h arrived with no message outstanding.", st);
        failures++;
        return;
      end
      m = pending.pop_front();
      checked++;
      if (m.stale) stale_seen++;
      if (m.length == mma_pkg::LenShort) short_seen++;
      if (st !== m.status) begin
        $error("msg_status: expected %h, got %h", m.status, st);
        failures++;
      end
      if (f !== m.first) begin
        $error("msg_first: expected %h, got %h", m.first, f);
        failures++;
      end
      if (s !== m.second) begin
        $error("msg_second: expected %h, got %h", m.second, s);
        failures++;
      end
      if (len !== m.length) begin
        $error("msg_length: expected %0d, got %0d", m.length, len);
        failures++;
      end
      if (stale !== m.stale) begin
        $error("second_stale: expected %b, got %b", m.stale, stale);
        failures++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] msg_status_o;
  logic [6:0] msg_first_o;
  logic [6:0] msg_second_o;
  logic [1:0] msg_length_o;
  logic       second_stale_o;

  midi_message_assembler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .msg_status_o  (msg_status_o),
    .msg_first_o   (msg_first_o),
    .msg_second_o  (msg_second_o),
    .msg_length_o  (msg_length_o),
    .second_stale_o(second_stale_o)
  );

  midi_msg_scoreboard msg_board = new();

  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned parsed_bytes;
  int unsigned burst_left;
  bit          quiet_stretch;
  int unsigned stall_mode;
  int unsigned stall_timer;

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        msg_board.check_msg(msg_status_o, msg_first_o, msg_second_o, msg_length_o,
                            second_stale_o);
      end
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(50, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] channel_status();
    logic [3:0] kind;
    logic [3:0] chan;
    kind = 4'($urandom_range(8, 14));
    chan = 4'($urandom_range(0, 15));
    return {kind, chan};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap_len;
    if (burst_left == 0) begin
      burst_left    = $urandom_range(1, 40);
      quiet_stretch = ($urandom_range(0, 3) == 0);
      gap_len       = quiet_stretch ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (msg_board.note_byte(b)) parsed_bytes++;
  endtask

  task automatic wait_for_messages();
    in_valid_i <= 1'b0;
    while (msg_board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_random_sequence();
    logic [7:0] seq[$];
    logic [7:0] st;
    int unsigned pick;
    int unsigned body;
    pick = $urandom_range(0, 99);
    st   = channel_status();
    if (pick < 70) begin
      seq.push_back(st);
      seq.push_back(data_byte());
      if (st[7:4] != mma_pkg::KindProgram && st[7:4] != mma_pkg::KindPressure) begin
        seq.push_back(data_byte());
      end
    end else if (pick < 78) begin
      st[7:4] = ($urandom_range(0, 1) == 0) ? 4'h8 : 4'hE;
      seq.push_back(st);
      seq.push_back(data_byte());
      seq.push_back(8'($urandom_range(128, 255)));
    end else if (pick < 84) begin
      seq.push_back(st);
      seq.push_back(8'($urandom_range(128, 255)));
    end else if (pick < 92) begin
      seq.push_back(mma_pkg::SysexStart);
      body = $urandom_range(0, 5);
      repeat (body) begin
        if ($urandom_range(0, 4) == 0) seq.push_back(8'($urandom_range(241, 255)));
        else seq.push_back(data_byte());
      end
      if ($urandom_range(0, 1) == 0) begin
        seq.push_back(mma_pkg::SysexEnd);
      end else begin
        seq.push_back(st);
        seq.push_back(data_byte());
        seq.push_back(data_byte());
      end
    end else begin
      body = $urandom_range(1, 4);
      repeat (body) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    logic [7:0] directed[$];
    bit         paused;
    bytes_sent    = 0;
    parsed_bytes  = 0;
    burst_left    = 0;
    quiet_stretch = 1'b0;
    stall_mode    = 0;
    stall_timer   = 0;
    paused        = 1'b0;
    directed = '{8'h00, 8'hFF, 8'h90, 8'h7F, 8'h00, 8'hC5, 8'h7F, 8'hD0, 8'h00,
                 8'hEF, 8'h85, 8'h80, 8'h12, 8'hF8, mma_pkg::SysexStart, 8'h55,
                 mma_pkg::SysexEnd, mma_pkg::SysexStart, 8'hB3, 8'h40, 8'h7F,
                 8'hA0, 8'h01, 8'hE2, mma_pkg::SysexEnd};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);
    wait_for_messages();

    while (bytes_sent < RandomItems) begin
      send_random_sequence();
      if (!paused && bytes_sent >= RandomItems / 2) begin
        wait_for_messages();
        paused = 1'b1;
      end
    end
    wait_for_messages();

    if (msg_board.pending.size() != 0) msg_board.failures++;
    $display("Sent %0d bytes, of which %0d moved the parser on; %0d messages checked,",
             bytes_sent, parsed_bytes, msg_board.checked);
    $display("%0d of them two-byte and %0d with a stale second byte.",
             msg_board.short_seen, msg_board.stale_seen);
    if (msg_board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
